// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the frustum cull RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/fcull_pkg.sv =====
// Types and constants of the frustum cull block
package fcull_pkg;
   localparam int unsigned PLANE_MAX = 6;
   localparam int unsigned IDX_W = 3;
   localparam int unsigned Q_DEPTH = 4;
   localparam int unsigned QPTR_W = 2;
   localparam logic FUNC_SPHERE = 1'b0;
   localparam logic FUNC_BOX = 1'b1;

   // one query as queued by the front end
   typedef struct packed {
      logic        is_box;
      logic [63:0] row_x;
      logic [63:0] row_y;
      logic [63:0] row_z;
      logic [47:0] lo;
      logic [47:0] hi;
      logic [47:0] center;
      logic [15:0] radius;
   } query_type;

   typedef struct packed {
      logic push;
      logic pop;
   } qctl_type;

   function automatic logic signed [15:0] lane16(input logic [63:0] v, input int unsigned k);
      lane16 = v[16*k +: 16];
   endfunction
endpackage

// ===== rtl/fcull_front.sv =====
// Front end: take queries and queue them
`include "assert_macros.svh"
module fcull_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  fcull_pkg::query_type  req_query,
   input  logic                  pop,
   output logic                  full,
   output logic                  empty,
   output fcull_pkg::query_type  head
);
   import fcull_pkg::*;

   query_type              q_ff [Q_DEPTH];
   logic [QPTR_W-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]        cnt_ff, cnt_in;

   // advance pointers and count
   always_comb begin
      wr_in  = wr_ff + QPTR_W'(req_valid);
      rd_in  = rd_ff + QPTR_W'(pop);
      cnt_in = cnt_ff + (QPTR_W+1)'(req_valid) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // store the transaction
   always_ff @(posedge clock) begin
      if (req_valid) begin
         q_ff[wr_ff] <= req_query;
      end
   end

   assign full  = (cnt_ff >= (QPTR_W+1)'(Q_DEPTH - 1));
   assign empty = (cnt_ff == '0);
   assign head  = q_ff[rd_ff];

   `ASSERT_IMPL(a_no_overflow, clock, reset, !(req_valid && cnt_ff == (QPTR_W+1)'(Q_DEPTH)),
      "queue overflow")
   `ASSERT_IMPL(a_no_underflow, clock, reset, !(pop && empty), "queue underflow")
   `ASSERT_IMPL(a_count, clock, reset, cnt_ff <= (QPTR_W+1)'(Q_DEPTH), "queue count range")
endmodule

// ===== rtl/fcull_back.sv =====
// Back end: transform box corners, low-z then high-z, and test them and spheres against the planes
`include "assert_macros.svh"
module fcull_back #(
   parameter int unsigned PLANE_COUNT = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  avail,
   input  fcull_pkg::query_type  head,
   input  logic [63:0]           planes [fcull_pkg::PLANE_MAX],
   output logic                  pop,
   output logic                  rsp_valid,
   output logic                  visible
);
   import fcull_pkg::*;

   // phase 0: the four low-z corners; phase 1: the four high-z corners. Stage A: transform.
   logic                     ph_ff, ph_in;
   logic                     a_vld_ff, a_box_ff, a_last_ff;
   logic signed [33:0]       pt_ff [4][3], pt_in [4][3];
   logic signed [47:0]       sd_ff [PLANE_MAX], sd_in [PLANE_MAX];
   logic                     b_last_ff;
   logic [PLANE_MAX-1:0]     in_ff, in_in;
   logic                     acc_in;
   logic                     vis_ff, rv_ff;

   always_comb begin
      ph_in = ph_ff;
      pop   = 1'b0;
      if (avail) begin
         if (head.is_box == FUNC_SPHERE) begin
            pop = 1'b1;
         end else begin
            pop   = ph_ff;
            ph_in = !ph_ff;
         end
      end
   end

   // transform four corners of this phase and compute the sphere distance to each plane
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 3; r++) begin
            logic [63:0] m;
            logic signed [15:0] x, y, z;
            m = (r == 0) ? head.row_x : (r == 1) ? head.row_y : head.row_z;
            x = (c[0]) ? head.hi[15:0] : head.lo[15:0];
            y = (c[1]) ? head.hi[31:16] : head.lo[31:16];
            z = (ph_ff) ? head.hi[47:32] : head.lo[47:32];
            pt_in[c][r] = 34'(lane16(m,0) * x) + 34'(lane16(m,1) * y)
                        + 34'(lane16(m,2) * z) + 34'(34'(lane16(m,3)) <<< 8);
         end
      end
      for (int i = 0; i < PLANE_MAX; i++) begin
         sd_in[i] = 48'(lane16(planes[i],0) * $signed(head.center[15:0]))
                  + 48'(lane16(planes[i],1) * $signed(head.center[31:16]))
                  + 48'(lane16(planes[i],2) * $signed(head.center[47:32]))
                  + 48'(48'(lane16(planes[i],3)) <<< 14)
                  + 48'(48'($signed(head.radius)) <<< 14);
      end
   end

   always_ff @(posedge clock) begin
      pt_ff     <= pt_in;
      sd_ff     <= sd_in;
      a_box_ff  <= head.is_box;
      a_last_ff <= pop;
   end

   // stage B: plane test over registered corners or registered sphere distances
   always_comb begin
      logic ok;
      in_in  = b_last_ff ? '0 : in_ff;
      ok     = 1'b1;
      for (int i = 0; i < PLANE_MAX; i++) begin
         for (int c = 0; c < 4; c++) begin
            logic signed [63:0] dot_sum;
            dot_sum = 64'(pt_ff[c][0] * lane16(planes[i],0))
                    + 64'(pt_ff[c][1] * lane16(planes[i],1))
                    + 64'(pt_ff[c][2] * lane16(planes[i],2))
                    + 64'(64'(lane16(planes[i],3)) <<< 22);
            if (dot_sum > 0) in_in[i] = 1'b1;
         end
         if (i < PLANE_COUNT) begin
            if (a_box_ff) ok = ok & in_in[i];
            else ok = ok & !sd_ff[i][47];
         end
      end
      acc_in = ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff    <= 1'b0;
         a_vld_ff <= 1'b0;
         rv_ff    <= 1'b0;
         in_ff    <= '0;
         b_last_ff <= 1'b1;
      end else begin
         ph_ff    <= ph_in;
         a_vld_ff <= avail;
         rv_ff    <= a_vld_ff && a_last_ff;
         if (a_vld_ff) begin
            in_ff     <= in_in;
            b_last_ff <= a_last_ff;
         end
      end
      vis_ff <= acc_in;
   end

   assign rsp_valid = rv_ff;
   assign visible   = vis_ff;

   `ASSERT_IMPL(a_sphere_one, clock, reset, (avail && !head.is_box) |-> pop,
      "sphere not taken in one cycle")
   `ASSERT_IMPL(a_box_two, clock, reset, (avail && head.is_box && !ph_ff) |=> ph_ff,
      "box phase lost")
   `ASSERT_IMPL(a_rsp, clock, reset, rsp_valid |-> $past(a_vld_ff && a_last_ff),
      "response without work")
endmodule

// ===== rtl/frustum_cull_test.sv =====
// Top level of the frustum cull block
// A query passes the queue, the stage A registers and the response registers.
// Throughput: a sphere query each cycle while busy is low; a box takes both z phases.
// A four-entry queue decouples intake from the test pipeline; busy rises when it nears full.
// rsp_valid is a one-cycle strobe; the receiver cannot stall.
// Synchronous active-high reset zeroes all plane registers and resets control state.
`include "assert_macros.svh"
module frustum_cull_test #(
   parameter int unsigned PLANE_COUNT = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_func,
   input  logic [63:0]        req_mat_row_x,
   input  logic [63:0]        req_mat_row_y,
   input  logic [63:0]        req_mat_row_z,
   input  logic [47:0]        req_box_low,
   input  logic [47:0]        req_box_high,
   input  logic [47:0]        req_sphere_center,
   input  logic signed [15:0] req_sphere_radius,
   output logic               rsp_valid,
   output logic               rsp_visible,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata
);
   import fcull_pkg::*;

   logic [63:0] plane_ff [PLANE_MAX];
   query_type   q_in, head;
   logic        full, empty, pop;

   // write plane registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PLANE_MAX; i++) plane_ff[i] <= '0;
      end else if (csr_we && csr_index < IDX_W'(PLANE_MAX)) begin
         plane_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      q_in.is_box = req_func;
      q_in.row_x  = req_mat_row_x;
      q_in.row_y  = req_mat_row_y;
      q_in.row_z  = req_mat_row_z;
      q_in.lo     = req_box_low;
      q_in.hi     = req_box_high;
      q_in.center = req_sphere_center;
      q_in.radius = req_sphere_radius;
   end

   assign busy = full;

   fcull_front u_front (
      .clock(clock), .reset(reset), .req_valid(start && !busy), .req_query(q_in),
      .pop(pop), .full(full), .empty(empty), .head(head)
   );

   fcull_back #(.PLANE_COUNT(PLANE_COUNT)) u_back (
      .clock(clock), .reset(reset), .avail(!empty), .head(head), .planes(plane_ff),
      .pop(pop), .rsp_valid(rsp_valid), .visible(rsp_visible)
   );
endmodule

// ===== test/cull_checker.sv =====
// Checker for the frustum cull block: predicts visibility and compares results
`timescale 1ns / 100ps
module cull_checker #(
   parameter int unsigned PLANE_COUNT = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic               req_func,
   input  logic [63:0]        req_mat_row_x,
   input  logic [63:0]        req_mat_row_y,
   input  logic [63:0]        req_mat_row_z,
   input  logic [47:0]        req_box_low,
   input  logic [47:0]        req_box_high,
   input  logic [47:0]        req_sphere_center,
   input  logic signed [15:0] req_sphere_radius,
   input  logic               rsp_valid,
   input  logic               rsp_visible,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata,
   output int                 fail_count,
   output int                 pending
);
   import fcull_pkg::*;

   logic [63:0] planes [PLANE_MAX];
   logic        visible_q[$];

   function automatic longint lane(input logic [63:0] v, input int k);
      logic signed [15:0] s;
      s = v[16*k +: 16];
      return longint'(s);
   endfunction

   // sphere passes unless some plane distance plus radius goes negative
   function automatic logic sphere_pass(input logic [47:0] c, input logic signed [15:0] r);
      longint dot_sum;
      for (int i = 0; i < PLANE_COUNT && i < PLANE_MAX; i++) begin
         dot_sum = lane(64'(c), 0) * lane(planes[i], 0) + lane(64'(c), 1) * lane(planes[i], 1)
                 + lane(64'(c), 2) * lane(planes[i], 2) + lane(planes[i], 3) * 16384
                 + longint'(r) * 16384;
         if (dot_sum < 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // box passes if every plane sees at least one transformed corner strictly inside
   function automatic logic box_pass(input logic [63:0] rx, input logic [63:0] ry,
                                     input logic [63:0] rz, input logic [47:0] lo,
                                     input logic [47:0] hi);
      longint pt [8][3];
      logic [63:0] rows [3];
      longint x, y, z, dot_sum;
      logic hit;
      rows[0] = rx; rows[1] = ry; rows[2] = rz;
      for (int c = 0; c < 8; c++) begin
         x = lane(64'(c[0] ? hi : lo), 0);
         y = lane(64'(c[1] ? hi : lo), 1);
         z = lane(64'(c[2] ? hi : lo), 2);
         for (int r = 0; r < 3; r++)
            pt[c][r] = lane(rows[r], 0) * x + lane(rows[r], 1) * y
                     + lane(rows[r], 2) * z + lane(rows[r], 3) * 256;
      end
      for (int i = 0; i < PLANE_COUNT && i < PLANE_MAX; i++) begin
         hit = 1'b0;
         for (int c = 0; c < 8; c++) begin
            dot_sum = pt[c][0] * lane(planes[i], 0) + pt[c][1] * lane(planes[i], 1)
                    + pt[c][2] * lane(planes[i], 2) + lane(planes[i], 3) * 4194304;
            if (dot_sum > 0) hit = 1'b1;
         end
         if (!hit) return 1'b0;
      end
      return 1'b1;
   endfunction

   assign pending = visible_q.size();

   // track plane writes, predict on each accepted transaction, check each strobe
   always @(posedge clock) begin
      logic exp_vis;
      if (reset) begin
         foreach (planes[i]) planes[i] = '0;
         visible_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we && csr_index < PLANE_MAX) planes[csr_index] = csr_wdata;
         if (start && !busy) begin
            if (req_func == FUNC_BOX)
               visible_q.push_back(box_pass(req_mat_row_x, req_mat_row_y, req_mat_row_z,
                                            req_box_low, req_box_high));
            else
               visible_q.push_back(sphere_pass(req_sphere_center, req_sphere_radius));
         end
         if (rsp_valid) begin
            if (visible_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result visible=%0b", rsp_visible);
            end else begin
               exp_vis = visible_q.pop_front();
               if (exp_vis !== rsp_visible) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("visible mismatch: expected %0b got %0b", exp_vis, rsp_visible);
               end
            end
         end
      end
   end
endmodule

// ===== test/tb_top.sv =====
// Stimulus and verdict for the frustum cull block
`timescale 1ns / 100ps
module tb_top;
   import fcull_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 450;
   localparam int TIMEOUT = 200000;

   logic               clock, reset, start, busy;
   logic               req_func;
   logic [63:0]        req_mat_row_x, req_mat_row_y, req_mat_row_z;
   logic [47:0]        req_box_low, req_box_high, req_sphere_center;
   logic signed [15:0] req_sphere_radius;
   logic               rsp_valid, rsp_visible;
   logic               csr_we;
   logic [2:0]         csr_index;
   logic [63:0]        csr_wdata;
   int                 fail_count, pending, cycles;
   int                 gap_left;

   frustum_cull_test DUT (.*);

   cull_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > TIMEOUT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [15:0] pick16(input int mode);
      case (mode)
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // small Q8.8 value, sometimes an extreme
   function automatic logic [15:0] coord16();
      if ($urandom_range(0, 9) == 0) return pick16($urandom_range(0, 3));
      return 16'(int'($urandom_range(0, 4096)) - 2048);
   endfunction

   // normal in Q1.14 with moderate offset, occasionally fully random
   function automatic logic [63:0] rand_plane();
      if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
      return {coord16(), 16'(int'($urandom_range(0, 32767)) - 16384),
              16'(int'($urandom_range(0, 32767)) - 16384),
              16'(int'($urandom_range(0, 32767)) - 16384)};
   endfunction

   function automatic logic [63:0] rand_row();
      if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
      return {coord16(), coord16(), coord16(), coord16()};
   endfunction

   function automatic logic [47:0] rand_vec();
      if ($urandom_range(0, 7) == 0) return {16'($urandom), $urandom};
      return {coord16(), coord16(), coord16()};
   endfunction

   // drive one register write and wait for the clock edge that takes it
   task automatic write_plane(input int idx, input logic [63:0] value);
      csr_we    <= 1'b1;
      csr_index <= 3'(idx);
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // hold until nothing is pending, then let the pipeline drain
   task automatic drain();
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // present one transaction and hold it until accepted
   task automatic send(input logic f, input logic [63:0] rx, input logic [63:0] ry,
                       input logic [63:0] rz, input logic [47:0] lo, input logic [47:0] hi,
                       input logic [47:0] c, input logic [15:0] r);
      if (gap_left == 0 && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start             <= 1'b1;
      req_func          <= f;
      req_mat_row_x     <= rx;
      req_mat_row_y     <= ry;
      req_mat_row_z     <= rz;
      req_box_low       <= lo;
      req_box_high      <= hi;
      req_sphere_center <= c;
      req_sphere_radius <= r;
      do @(posedge clock); while (busy);
      if (gap_left > 0) gap_left--;
      else if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(5, 30);
   endtask

   task automatic send_random();
      send(1'($urandom), rand_row(), rand_row(), rand_row(), rand_vec(), rand_vec(),
           rand_vec(), coord16());
      if ($urandom_range(0, 1) == 0) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic load_planes(input int mode);
      for (int i = 0; i < 6; i++)
         case (mode)
            0: write_plane(i, 64'h0);
            1: write_plane(i, 64'hFFFF_FFFF_FFFF_FFFF);
            2: write_plane(i, 64'h7FFF_7FFF_7FFF_7FFF);
            3: write_plane(i, 64'h8000_8000_8000_8000);
            default: write_plane(i, rand_plane());
         endcase
      // ignored index
      write_plane(6 + $urandom_range(0, 1), {$urandom, $urandom});
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [63:0] ident_x, ident_y, ident_z;
      cycles = 0; gap_left = 0;
      start = 1'b0; req_func = FUNC_SPHERE;
      req_mat_row_x = '0; req_mat_row_y = '0; req_mat_row_z = '0;
      req_box_low = '0; req_box_high = '0; req_sphere_center = '0; req_sphere_radius = '0;
      csr_we = 1'b0; csr_index = '0; csr_wdata = '0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      ident_x = 64'h0000_0000_0000_0100;
      ident_y = 64'h0000_0000_0100_0000;
      ident_z = 64'h0000_0100_0000_0000;

      // directed: planes at reset, zero/negative radius, every box rejected
      send(FUNC_SPHERE, '1, '1, '1, '1, '1, 48'h0, 16'h0000);
      send(FUNC_SPHERE, '0, '0, '0, '0, '0, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
      send(FUNC_SPHERE, '0, '0, '0, '0, '0, 48'h7FFF_8000_7FFF, 16'h7FFF);
      send(FUNC_BOX, ident_x, ident_y, ident_z, 48'h0, 48'h0100_0100_0100, '1, '1);
      start <= 1'b0;
      drain();

      // directed: extreme planes and extreme fields, swapped corners
      for (int m = 1; m < 4; m++) begin
         load_planes(m);
         send(FUNC_SPHERE, '0, '0, '0, '0, '0, 48'h7FFF_7FFF_7FFF, 16'h7FFF);
         send(FUNC_SPHERE, '1, '1, '1, '1, '1, 48'h8000_8000_8000, 16'h8000);
         send(FUNC_BOX, '1, '1, '1, 48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, '0, '0);
         send(FUNC_BOX, 64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
              64'h7FFF_8000_7FFF_8000, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, '1, '1);
         send(FUNC_BOX, ident_x, ident_y, ident_z, 48'h0100_0100_0100, 48'h0, '0, '0);
         start <= 1'b0;
         drain();
      end

      // random phases under several plane sets
      for (int ph = 0; ph < 9; ph++) begin
         load_planes(ph == 0 ? 0 : 4);
         for (int n = 0; n < RANDOM_ITEMS / 9; n++) send_random();
         start <= 1'b0;
         drain();
      end

      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule

// ===== frustum_cull_test.f =====
+incdir+rtl
rtl/fcull_pkg.sv
rtl/fcull_front.sv
rtl/fcull_back.sv
rtl/frustum_cull_test.sv
test/cull_checker.sv
test/tb_top.sv
